### hw/rtl/ckc_pkg.sv
// Shared constants, types and codes of the canonical k-mer counter.
`default_nettype none
package ckc_pkg;

    localparam int MAX_ORDER  = 8;
    localparam int COUNT_BITS = 32;
    localparam int TOTAL_BITS = 48;
    localparam int KLEN_BITS  = 4;
    localparam int KCODE_W    = 16;
    localparam int CODE_BITS  = 2 * MAX_ORDER;
    localparam int ADDR_BITS  = CODE_BITS + 1;
    localparam int TABLE_DEPTH = 2 ** ADDR_BITS;
    localparam int RUN_BITS   = $clog2(MAX_ORDER + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KLEN_BITS-1:0] KLEN_RESET = KLEN_BITS'(8);
    localparam logic [KLEN_BITS-1:0] KLEN_MIN   = KLEN_BITS'(2);
    localparam logic [KLEN_BITS-1:0] KLEN_MAX   = KLEN_BITS'(MAX_ORDER);

    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_G  = 8'h47;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_NU = 8'h4E;
    localparam logic [7:0] CH_NL = 8'h6E;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_COUNT = 2'd1,
        K_READ  = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        B_INIT  = 2'd0,
        B_IDLE  = 2'd1,
        B_RMW   = 2'd2,
        B_CLEAR = 2'd3
    } t_bstate;

    typedef struct packed {
        t_kind                 kind;
        logic                  set;
        logic [KCODE_W-1:0]    code;
        logic [TOTAL_BITS-1:0] total;
    } t_entry;

    typedef struct packed {
        logic                  strobe;
        logic                  kmer_valid;
        logic [KCODE_W-1:0]    kmer_code;
        logic [COUNT_BITS-1:0] count_value;
        logic [TOTAL_BITS-1:0] total_non_n;
    } t_result;

endpackage
`default_nettype wire

### hw/rtl/ckc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ckc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/ckc_front.sv
// Front end: base window, canonical code, non-N totals and command classification.
`default_nettype none
module ckc_front import ckc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_operation,
    input  wire logic                 i_set_select,
    input  wire logic                 i_sequence_start,
    input  wire logic [7:0]           i_base_char,
    input  wire logic [15:0]          i_read_index,
    input  wire logic                 i_cfg_we,
    input  wire logic [KLEN_BITS-1:0] i_cfg_data,
    output logic                      o_push,
    output t_entry                    o_entry
);

    logic [KLEN_BITS-1:0]  r_klen;
    logic [CODE_BITS-1:0]  r_window, n_window;
    logic [RUN_BITS-1:0]   r_run, n_run;
    logic [TOTAL_BITS-1:0] r_total [2];
    logic [TOTAL_BITS-1:0] n_total;

    logic [KLEN_BITS-1:0]  k_eff;
    logic [CODE_BITS-1:0]  win_base, rc_full, rc_k, fwd, canon;
    logic [RUN_BITS-1:0]   run_base;
    logic [1:0]            base;
    logic                  base_ok;
    logic                  non_n;
    logic [TOTAL_BITS-1:0] tot_sel;

    always_comb begin
        if (r_klen < KLEN_MIN) begin
            k_eff = KLEN_MIN;
        end else if (r_klen > KLEN_MAX) begin
            k_eff = KLEN_MAX;
        end else begin
            k_eff = r_klen;
        end

        base_ok = 1'b1;
        case (i_base_char)
            CH_A: base = 2'd0;
            CH_C: base = 2'd1;
            CH_G: base = 2'd2;
            CH_T: base = 2'd3;
            default: begin
                base    = 2'd0;
                base_ok = 1'b0;
            end
        endcase

        win_base = i_sequence_start ? '0 : r_window;
        run_base = i_sequence_start ? '0 : r_run;

        if (base_ok) begin
            n_window = {win_base[CODE_BITS-3:0], base};
            n_run    = (run_base < RUN_BITS'(MAX_ORDER)) ? run_base + 1'b1 : run_base;
        end else begin
            n_window = win_base;
            n_run    = '0;
        end

        // reverse complement over the full window, then aligned down to k bases
        for (int i = 0; i < MAX_ORDER; i++) begin
            rc_full[2*(MAX_ORDER-1-i) +: 2] = ~n_window[2*i +: 2];
        end
        rc_k  = rc_full >> (2 * (MAX_ORDER - int'(k_eff)));
        fwd   = n_window & ~({CODE_BITS{1'b1}} << (2 * int'(k_eff)));
        canon = (rc_k < fwd) ? rc_k : fwd;

        non_n   = !(i_base_char inside {CH_NU, CH_NL});
        tot_sel = r_total[i_set_select];
        n_total = (non_n && (tot_sel != {TOTAL_BITS{1'b1}})) ? tot_sel + 1'b1 : tot_sel;

        o_entry.set   = i_set_select;
        o_entry.kind  = K_NONE;
        o_entry.code  = '0;
        o_entry.total = '0;
        case (t_op'(i_operation))
            OP_PUSH: begin
                o_entry.total = n_total;
                if (base_ok && (n_run >= RUN_BITS'(k_eff))) begin
                    o_entry.kind = K_COUNT;
                    o_entry.code = KCODE_W'(canon);
                end
            end
            OP_READ: begin
                o_entry.kind  = K_READ;
                o_entry.code  = i_read_index;
                o_entry.total = tot_sel;
            end
            OP_CLEAR: begin
                o_entry.kind = K_CLEAR;
            end
            default: begin
                o_entry.kind = K_NONE;
            end
        endcase
    end

    assign o_push = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen     <= KLEN_RESET;
            r_window   <= '0;
            r_run      <= '0;
            r_total[0] <= '0;
            r_total[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_klen <= i_cfg_data;
            end
            if (i_accept) begin
                case (t_op'(i_operation))
                    OP_PUSH: begin
                        r_window <= n_window;
                        r_run    <= n_run;
                        r_total[i_set_select] <= n_total;
                    end
                    OP_CLEAR: begin
                        r_total[i_set_select] <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ckc_queue.sv
// Short command queue between front end and back end.
`default_nettype none
module ckc_queue import ckc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_entry    i_data,
    input  wire logic i_pop,
    output t_entry    o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr, r_rd;
    logic [PTR_BITS:0]     r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PTR_BITS+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ckc_back.sv
// Back end: count table read-modify-write, clear sweeps and result register.
`default_nettype none
module ckc_back import ckc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_entry    i_head,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_init,
    output t_result   o_result
);

    t_bstate               r_state, n_state;
    t_entry                r_cur, n_cur;
    logic [ADDR_BITS-1:0]  r_sweep, n_sweep;
    t_result               r_res, n_res;

    logic                  we;
    logic [ADDR_BITS-1:0]  waddr, raddr;
    logic [COUNT_BITS-1:0] wdata, rdata, inc;

    ckc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign inc = (rdata == {COUNT_BITS{1'b1}}) ? rdata : rdata + 1'b1;

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_sweep = r_sweep;
        n_res   = r_res;
        n_res.strobe = 1'b0;
        o_pop   = 1'b0;
        we      = 1'b0;
        waddr   = {r_cur.set, r_cur.code[CODE_BITS-1:0]};
        wdata   = '0;
        raddr   = {i_head.set, i_head.code[CODE_BITS-1:0]};

        case (r_state)
            B_INIT: begin
                we      = 1'b1;
                waddr   = r_sweep;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == {ADDR_BITS{1'b1}}) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cur = i_head;
                    if (i_head.kind inside {K_COUNT, K_READ}) begin
                        n_state = B_RMW;
                    end else begin
                        n_res.strobe      = 1'b1;
                        n_res.kmer_valid  = 1'b0;
                        n_res.kmer_code   = '0;
                        n_res.count_value = '0;
                        n_res.total_non_n = i_head.total;
                        if (i_head.kind == K_CLEAR) begin
                            n_sweep = '0;
                            n_state = B_CLEAR;
                        end
                    end
                end
            end
            B_RMW: begin
                n_res.strobe      = 1'b1;
                n_res.kmer_code   = r_cur.code;
                n_res.total_non_n = r_cur.total;
                if (r_cur.kind == K_COUNT) begin
                    we                = 1'b1;
                    wdata             = inc;
                    n_res.kmer_valid  = 1'b1;
                    n_res.count_value = inc;
                end else begin
                    n_res.kmer_valid  = 1'b0;
                    n_res.count_value = rdata;
                end
                n_state = B_IDLE;
            end
            B_CLEAR: begin
                we      = 1'b1;
                waddr   = {r_cur.set, r_sweep[CODE_BITS-1:0]};
                n_sweep = r_sweep + 1'b1;
                if (r_sweep[CODE_BITS-1:0] == {CODE_BITS{1'b1}}) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_sweep <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    assign o_init   = (r_state == B_INIT);
    assign o_result = r_res;

endmodule
`default_nettype wire

### hw/rtl/canonical_kmer_counter.sv
// Top level of the canonical k-mer counter: front end, queue and back end.
// Order: a count or read passes the queue, the count RAM read and the result register
// before its strobe, other commands only the queue and the result register.
// The back end takes a new command only after the read-modify-write of a count or read
// on the single-write-port count RAM is done; a clear holds the back end while it sweeps
// every entry of its set. Reset: a sweep zeroes the whole count RAM with busy high;
// results cannot be stalled by the receiver.
`default_nettype none
module canonical_kmer_counter import ckc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_operation,
    input  wire logic                  i_set_select,
    input  wire logic                  i_sequence_start,
    input  wire logic [7:0]            i_base_char,
    input  wire logic [15:0]           i_read_index,
    input  wire logic                  i_cfg_we,
    input  wire logic [KLEN_BITS-1:0]  i_cfg_data,
    output logic                       strobe,
    output logic                       o_kmer_valid,
    output logic [KCODE_W-1:0]         o_kmer_code,
    output logic [COUNT_BITS-1:0]      o_count_value,
    output logic [TOTAL_BITS-1:0]      o_total_non_n
);

    logic    accept;
    logic    q_push, q_pop, q_empty, q_full;
    logic    back_init;
    t_entry  entry, head;
    t_result result;

    assign busy   = q_full | back_init;
    assign accept = start & ~busy;

    ckc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_set_select    (i_set_select),
        .i_sequence_start(i_sequence_start),
        .i_base_char     (i_base_char),
        .i_read_index    (i_read_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_push          (q_push),
        .o_entry         (entry)
    );

    ckc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (entry),
        .i_pop  (q_pop),
        .o_head (head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    ckc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_init  (back_init),
        .o_result(result)
    );

    assign strobe        = result.strobe;
    assign o_kmer_valid  = result.kmer_valid;
    assign o_kmer_code   = result.kmer_code;
    assign o_count_value = result.count_value;
    assign o_total_non_n = result.total_non_n;

    // no result leaves while the reset sweep is still zeroing the table
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_init |-> !strobe)
        else $error("result strobe during reset sweep");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // a counted k-mer was just incremented, so its count cannot be zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_kmer_valid) |-> (o_count_value != '0))
        else $error("counted k-mer returned zero count");

endmodule
`default_nettype wire
